### sv/snd_pkg.sv
// snd_pkg: constants and types shared by the nested sha-1 digest unit
// no dependencies
package snd_pkg;
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last_byte;
    } snd_in_t;

    typedef struct packed {
        logic [63:0] digest_upper;
        logic [63:0] digest_lower;
    } snd_out_t;

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] k;
        if (t < 7'd20)      k = 32'h5A827999;
        else if (t < 7'd40) k = 32'h6ED9EBA1;
        else if (t < 7'd60) k = 32'h8F1BBCDC;
        else                k = 32'hCA62C1D6;
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] t,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        if (t < 7'd20)      f = (b & c) | (~b & d);
        else if (t < 7'd40) f = b ^ c ^ d;
        else if (t < 7'd60) f = (b & c) | (b & d) | (c & d);
        else                f = b ^ c ^ d;
        return f;
    endfunction
endpackage

### sv/snd_if.sv
// snd_in_if / snd_out_if: valid-ready channels of the digest unit
// depends on snd_pkg
interface snd_in_if;
    logic              valid;
    logic              ready;
    snd_pkg::snd_in_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface snd_out_if;
    logic              valid;
    logic              ready;
    snd_pkg::snd_out_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### sv/sha1_nested_digest_unit.sv
// sha1_nested_digest_unit: byte-fed sha-1, then a second sha-1 over a block
// built from the first digest; depends on snd_pkg and snd_if.sv
//
// One message byte per input transfer. A byte that does not close a 64-byte
// block only goes into the block buffer; a byte that closes one starts a
// compression in the single shared round unit (one sha-1 round a cycle over
// a 16-word rolling schedule in ST_ROUND, then an add into the chain in
// ST_ADD). An item with last_byte runs padding (pad bytes one by one in
// ST_PAD, plus one or two more compressions), builds the second block in
// ST_BUILD and compresses it twice (ST_FEED and the data block, ST_PAD and
// the pad block), with any wait in ST_OUT for the output register to empty.
// The result sits in an output register; the next message may start while it
// waits to be taken. No clearing pass after reset.
module sha1_nested_digest_unit #(
    parameter int LENGTH_COUNTER_BITS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    snd_in_if.sink     in_ch,
    snd_out_if.source  out_ch
);
    import snd_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_ROUND = 8'b0000_0010,
        ST_ADD   = 8'b0000_0100,
        ST_PAD   = 8'b0000_1000,
        ST_BUILD = 8'b0001_0000,
        ST_FEED  = 8'b0010_0000,
        ST_OUT   = 8'b0100_0000,
        ST_WAIT  = 8'b1000_0000
    } state_t;

    state_t      state_reg;
    logic [31:0] h_reg [5];
    logic [31:0] w_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [LENGTH_COUNTER_BITS-1:0] len_reg;
    logic [LENGTH_COUNTER_BITS-1:0] len_inc;
    logic [63:0] pad_len_reg;
    logic [5:0]  fill_reg;
    logic [6:0]  round_reg;
    logic        second_reg;
    logic        finishing_reg;   // padding phase in progress
    logic        pad_first_reg;   // 0x80 byte still to go
    logic        pad_wrap_reg;    // 0x80 landed past byte 55, length goes in next block
    logic [5:0]  feed_reg;
    logic [7:0]  blk_reg [32];    // built block, upper half zero
    logic        out_valid_reg;
    snd_out_t    out_reg;

    // byte to absorb this cycle
    logic [7:0]  ab_byte;
    logic        ab_en;
    logic [3:0]  ab_word;
    logic [1:0]  ab_lane;
    logic [5:0]  len_idx;

    assign ab_word = fill_reg[5:2];
    assign ab_lane = fill_reg[1:0];
    assign len_idx = fill_reg - 6'd56;
    assign len_inc = len_reg + LENGTH_COUNTER_BITS'(8);

    always_comb
    begin
        ab_en   = 1'b0;
        ab_byte = 8'h00;
        unique case (state_reg)
            ST_IDLE:
            begin
                ab_en   = in_ch.valid && in_ch.payload.byte_present;
                ab_byte = in_ch.payload.data_byte;
            end
            ST_PAD:
            begin
                ab_en = 1'b1;
                if (pad_first_reg)
                    ab_byte = 8'h80;
                else if (fill_reg >= 6'd56 && !pad_wrap_reg)
                    ab_byte = pad_len_reg[8*(7-len_idx[2:0]) +: 8];
                else
                    ab_byte = 8'h00;
            end
            ST_FEED:
            begin
                ab_en   = 1'b1;
                ab_byte = feed_reg[5] ? 8'h00 : blk_reg[feed_reg[4:0]];
            end
            default:
            begin
                ab_en   = 1'b0;
                ab_byte = 8'h00;
            end
        endcase
    end

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = out_reg;

    // shared round unit
    logic [31:0] w_new, tmp;
    assign w_new = {w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]} << 1
                 | {w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]} >> 31;
    assign tmp = {a_reg[26:0], a_reg[31:27]} + round_f(round_reg, b_reg, c_reg, d_reg)
               + e_reg + round_k(round_reg) + w_reg[0];

    // digest bytes of the first pass
    logic [7:0] dg [20];
    always_comb
    begin
        for (int i = 0; i < 20; i++)
            dg[i] = h_reg[i/4][8*(3-(i%4)) +: 8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            h_reg[0] <= IV0; h_reg[1] <= IV1; h_reg[2] <= IV2;
            h_reg[3] <= IV3; h_reg[4] <= IV4;
            for (int i = 0; i < 16; i++)
                w_reg[i] <= '0;
            for (int i = 0; i < 32; i++)
                blk_reg[i] <= '0;
            a_reg <= '0; b_reg <= '0; c_reg <= '0; d_reg <= '0; e_reg <= '0;
            len_reg       <= '0;
            pad_len_reg   <= '0;
            fill_reg      <= '0;
            round_reg     <= '0;
            second_reg    <= 1'b0;
            finishing_reg <= 1'b0;
            pad_first_reg <= 1'b0;
            pad_wrap_reg  <= 1'b0;
            feed_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready && state_reg != ST_OUT)
                out_valid_reg <= 1'b0;

            // byte into the block buffer
            if (ab_en)
            begin
                if (ab_lane == 2'd0)
                    w_reg[ab_word] <= {ab_byte, 24'h0};
                else
                    w_reg[ab_word][8*(3-ab_lane) +: 8] <= ab_byte;
                fill_reg <= fill_reg + 6'd1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        if (in_ch.payload.byte_present)
                            len_reg <= len_inc;
                        finishing_reg <= in_ch.payload.last_byte;
                        pad_first_reg <= 1'b1;
                        pad_len_reg   <= in_ch.payload.byte_present ? 64'(len_inc)
                                                                    : 64'(len_reg);
                        if (ab_en && fill_reg == 6'd63)
                            state_reg <= ST_ROUND;
                        else if (in_ch.payload.last_byte)
                            state_reg <= ST_PAD;
                    end
                    a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                    d_reg <= h_reg[3]; e_reg <= h_reg[4];
                    round_reg <= '0;
                end
                ST_ROUND:
                begin
                    e_reg <= d_reg; d_reg <= c_reg;
                    c_reg <= {b_reg[1:0], b_reg[31:2]};
                    b_reg <= a_reg; a_reg <= tmp;
                    for (int i = 0; i < 15; i++)
                        w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= w_new;
                    if (round_reg == 7'd79)
                    begin
                        round_reg <= '0;
                        state_reg <= ST_ADD;
                    end
                    else
                        round_reg <= round_reg + 7'd1;
                end
                ST_ADD:
                begin
                    h_reg[0] <= h_reg[0] + a_reg; h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg; h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    if (!finishing_reg)
                        state_reg <= ST_IDLE;
                    else if (pad_first_reg)
                        state_reg <= ST_PAD;
                    else if (pad_wrap_reg)
                    begin
                        // length block still to go
                        pad_wrap_reg <= 1'b0;
                        state_reg    <= ST_PAD;
                    end
                    else
                        state_reg <= second_reg ? ST_OUT : ST_BUILD;
                end
                ST_PAD:
                begin
                    pad_first_reg <= 1'b0;
                    if (pad_first_reg && fill_reg >= 6'd56)
                        pad_wrap_reg <= 1'b1;
                    a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                    d_reg <= h_reg[3]; e_reg <= h_reg[4];
                    if (fill_reg == 6'd63)
                        state_reg <= ST_ROUND;
                end
                ST_BUILD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        blk_reg[i]    <= dg[4+i];
                        blk_reg[8+i]  <= dg[4+i];
                    end
                    for (int i = 0; i < 4; i++)
                    begin
                        blk_reg[16+i] <= dg[12+i];
                        blk_reg[24+i] <= dg[12+i];
                    end
                    blk_reg[20] <= dg[16]; blk_reg[28] <= dg[16];
                    for (int i = 0; i < 3; i++)
                    begin
                        blk_reg[21+i] <= dg[1+i];
                        blk_reg[29+i] <= dg[1+i];
                    end
                    h_reg[0] <= IV0; h_reg[1] <= IV1; h_reg[2] <= IV2;
                    h_reg[3] <= IV3; h_reg[4] <= IV4;
                    second_reg    <= 1'b1;
                    pad_first_reg <= 1'b1;
                    pad_len_reg   <= 64'd512;
                    feed_reg      <= '0;
                    state_reg     <= ST_FEED;
                end
                ST_FEED:
                begin
                    // counter wraps to zero after the last byte
                    feed_reg <= feed_reg + 6'd1;
                    a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                    d_reg <= h_reg[3]; e_reg <= h_reg[4];
                    if (feed_reg == 6'd63)
                        state_reg <= ST_ROUND;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_reg.digest_upper <= {h_reg[0], h_reg[1]};
                        out_reg.digest_lower <= {h_reg[2], h_reg[3]};
                        out_valid_reg <= 1'b1;
                        h_reg[0] <= IV0; h_reg[1] <= IV1; h_reg[2] <= IV2;
                        h_reg[3] <= IV3; h_reg[4] <= IV4;
                        len_reg       <= '0;
                        second_reg    <= 1'b0;
                        finishing_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
